[rtl/fsk_pkg.sv]
// shared types and constants for the fsk tone sequencer
// no dependencies

package fsk_pkg;

   localparam int FREQ_W = 15;
   localparam int LEN_W  = 16;
   localparam int CNT_W  = 4;
   localparam int WORD_W = 8;
   localparam int IDX_W  = 3;
   localparam int CSR_W  = 16;

   localparam logic [CNT_W-1:0] MAX_WORD_BITS = 4'd8;

   // register indexes
   localparam logic [IDX_W-1:0] REG_MARK_FREQ     = 3'd0;
   localparam logic [IDX_W-1:0] REG_SPACE_FREQ    = 3'd1;
   localparam logic [IDX_W-1:0] REG_BIT_SAMPLES   = 3'd2;
   localparam logic [IDX_W-1:0] REG_STOP_SAMPLES  = 3'd3;
   localparam logic [IDX_W-1:0] REG_DATA_BITS     = 3'd4;
   localparam logic [IDX_W-1:0] REG_LEADER_BITS   = 3'd5;
   localparam logic [IDX_W-1:0] REG_TRAILER_BITS  = 3'd6;
   localparam logic [IDX_W-1:0] REG_FLUSH_SAMPLES = 3'd7;

   // register reset values
   localparam logic [FREQ_W-1:0] RST_MARK_FREQ     = 15'd1270;
   localparam logic [FREQ_W-1:0] RST_SPACE_FREQ    = 15'd1070;
   localparam logic [LEN_W-1:0]  RST_BIT_SAMPLES   = 16'd160;
   localparam logic [LEN_W-1:0]  RST_STOP_SAMPLES  = 16'd160;
   localparam logic [CNT_W-1:0]  RST_DATA_BITS     = 4'd8;
   localparam logic [CNT_W-1:0]  RST_LEADER_BITS   = 4'd2;
   localparam logic [CNT_W-1:0]  RST_TRAILER_BITS  = 4'd2;
   localparam logic [LEN_W-1:0]  RST_FLUSH_SAMPLES = 16'd24000;

   // input op codes
   localparam logic OP_SEND = 1'b0;
   localparam logic OP_END  = 1'b1;

   // segment kinds
   typedef enum logic [2:0] {
      SEG_MARK,
      SEG_SPACE,
      SEG_DATA,
      SEG_STOP,
      SEG_FLUSH
   } seg_kind_type;

   // counter load sources
   typedef enum logic [1:0] {
      CNT_SRC_LEADER,
      CNT_SRC_DATA,
      CNT_SRC_TRAILER
   } cnt_src_type;

   typedef struct packed {
      logic         accept;
      logic         emit;
      seg_kind_type seg_kind;
      logic         seg_last;
      logic         cnt_load;
      cnt_src_type  cnt_src;
      logic         cnt_dec;
      logic         shift;
      logic         set_tx;
      logic         clr_tx;
   } cmd_type;

   typedef struct packed {
      logic op;
      logic transmitting;
      logic cnt_zero;
      logic out_free;
   } status_type;

endpackage

[rtl/fsk_req_if.sv]
// input channel of the fsk tone sequencer: op and data word
// depends on fsk_pkg

interface fsk_req_if;
   import fsk_pkg::*;

   logic              valid;
   logic              ready;
   logic              op;
   logic [WORD_W-1:0] data_word;

   modport source (output valid, output op, output data_word, input ready);
   modport sink   (input valid, input op, input data_word, output ready);
endinterface

[rtl/fsk_rsp_if.sv]
// result channel of the fsk tone sequencer: one tone segment per beat
// depends on fsk_pkg

interface fsk_rsp_if;
   import fsk_pkg::*;

   logic              valid;
   logic              ready;
   logic [FREQ_W-1:0] seg_freq;
   logic [LEN_W-1:0]  duration;
   logic              last;

   modport source (output valid, output seg_freq, output duration, output last,
                   input ready);
   modport sink   (input valid, input seg_freq, input duration, input last,
                   output ready);
endinterface

[rtl/fsk_ctrl.sv]
// segment sequencing state machine of the fsk tone sequencer
// depends on fsk_pkg; drives the datapath by command struct

module fsk_ctrl
   import fsk_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_DISPATCH = 3'd1;
   localparam logic [2:0] ST_LEADER   = 3'd2;
   localparam logic [2:0] ST_START    = 3'd3;
   localparam logic [2:0] ST_DATA     = 3'd4;
   localparam logic [2:0] ST_STOP     = 3'd5;
   localparam logic [2:0] ST_TRAILER  = 3'd6;
   localparam logic [2:0] ST_FLUSH    = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.seg_kind = SEG_MARK;
      cmd.cnt_src  = CNT_SRC_LEADER;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (status.op == OP_END) begin
               if (status.transmitting) begin
                  cmd.cnt_load = 1'b1;
                  cmd.cnt_src  = CNT_SRC_TRAILER;
                  state_in     = ST_TRAILER;
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (!status.transmitting) begin
               cmd.set_tx   = 1'b1;
               cmd.cnt_load = 1'b1;
               cmd.cnt_src  = CNT_SRC_LEADER;
               state_in     = ST_LEADER;
            end else begin
               state_in = ST_START;
            end
         end
         ST_LEADER: begin
            if (status.cnt_zero) begin
               state_in = ST_START;
            end else if (status.out_free) begin
               cmd.emit     = 1'b1;
               cmd.seg_kind = SEG_MARK;
               cmd.cnt_dec  = 1'b1;
            end
         end
         ST_START: begin
            if (status.out_free) begin
               cmd.emit     = 1'b1;
               cmd.seg_kind = SEG_SPACE;
               cmd.cnt_load = 1'b1;
               cmd.cnt_src  = CNT_SRC_DATA;
               state_in     = ST_DATA;
            end
         end
         ST_DATA: begin
            if (status.cnt_zero) begin
               state_in = ST_STOP;
            end else if (status.out_free) begin
               cmd.emit     = 1'b1;
               cmd.seg_kind = SEG_DATA;
               cmd.cnt_dec  = 1'b1;
               cmd.shift    = 1'b1;
            end
         end
         ST_STOP: begin
            if (status.out_free) begin
               cmd.emit     = 1'b1;
               cmd.seg_kind = SEG_STOP;
               cmd.seg_last = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_TRAILER: begin
            if (status.cnt_zero) begin
               state_in = ST_FLUSH;
            end else if (status.out_free) begin
               cmd.emit     = 1'b1;
               cmd.seg_kind = SEG_MARK;
               cmd.cnt_dec  = 1'b1;
            end
         end
         ST_FLUSH: begin
            if (status.out_free) begin
               cmd.emit     = 1'b1;
               cmd.seg_kind = SEG_FLUSH;
               cmd.seg_last = 1'b1;
               cmd.clr_tx   = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/fsk_dp.sv]
// datapath of the fsk tone sequencer: registers, word shifter, bit counter,
// output register; depends on fsk_pkg, driven by fsk_ctrl

module fsk_dp
   import fsk_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]  csr_wdata,
   input  logic              req_op,
   input  logic [WORD_W-1:0] req_data_word,
   input  cmd_type           cmd,
   output status_type        status,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [FREQ_W-1:0] rsp_seg_freq,
   output logic [LEN_W-1:0]  rsp_duration,
   output logic              rsp_last
);

   logic [FREQ_W-1:0] mark_freq_ff;
   logic [FREQ_W-1:0] space_freq_ff;
   logic [LEN_W-1:0]  bit_samples_ff;
   logic [LEN_W-1:0]  stop_samples_ff;
   logic [CNT_W-1:0]  data_bits_ff;
   logic [CNT_W-1:0]  leader_bits_ff;
   logic [CNT_W-1:0]  trailer_bits_ff;
   logic [LEN_W-1:0]  flush_samples_ff;

   logic              op_ff;
   logic [WORD_W-1:0] word_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [CNT_W-1:0]  cnt_in;
   logic              tx_ff;
   logic              valid_ff;
   logic [FREQ_W-1:0] freq_ff;
   logic [FREQ_W-1:0] freq_in;
   logic [LEN_W-1:0]  len_ff;
   logic [LEN_W-1:0]  len_in;
   logic              last_ff;
   logic [CNT_W-1:0]  nbits;

   always_ff @(posedge clock) begin
      if (reset) begin
         mark_freq_ff     <= RST_MARK_FREQ;
         space_freq_ff    <= RST_SPACE_FREQ;
         bit_samples_ff   <= RST_BIT_SAMPLES;
         stop_samples_ff  <= RST_STOP_SAMPLES;
         data_bits_ff     <= RST_DATA_BITS;
         leader_bits_ff   <= RST_LEADER_BITS;
         trailer_bits_ff  <= RST_TRAILER_BITS;
         flush_samples_ff <= RST_FLUSH_SAMPLES;
      end else if (csr_we) begin
         case (csr_index)
            REG_MARK_FREQ:     mark_freq_ff     <= csr_wdata[FREQ_W-1:0];
            REG_SPACE_FREQ:    space_freq_ff    <= csr_wdata[FREQ_W-1:0];
            REG_BIT_SAMPLES:   bit_samples_ff   <= csr_wdata[LEN_W-1:0];
            REG_STOP_SAMPLES:  stop_samples_ff  <= csr_wdata[LEN_W-1:0];
            REG_DATA_BITS:     data_bits_ff     <= csr_wdata[CNT_W-1:0];
            REG_LEADER_BITS:   leader_bits_ff   <= csr_wdata[CNT_W-1:0];
            REG_TRAILER_BITS:  trailer_bits_ff  <= csr_wdata[CNT_W-1:0];
            REG_FLUSH_SAMPLES: flush_samples_ff <= csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // word holds at most eight bits
   assign nbits = (data_bits_ff > MAX_WORD_BITS) ? MAX_WORD_BITS : data_bits_ff;

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.cnt_load) begin
         case (cmd.cnt_src)
            CNT_SRC_LEADER:  cnt_in = leader_bits_ff;
            CNT_SRC_DATA:    cnt_in = nbits;
            CNT_SRC_TRAILER: cnt_in = trailer_bits_ff;
            default:         cnt_in = '0;
         endcase
      end else if (cmd.cnt_dec) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_comb begin
      case (cmd.seg_kind)
         SEG_MARK: begin
            freq_in = mark_freq_ff;
            len_in  = bit_samples_ff;
         end
         SEG_SPACE: begin
            freq_in = space_freq_ff;
            len_in  = bit_samples_ff;
         end
         SEG_DATA: begin
            freq_in = word_ff[0] ? mark_freq_ff : space_freq_ff;
            len_in  = bit_samples_ff;
         end
         SEG_STOP: begin
            freq_in = mark_freq_ff;
            len_in  = stop_samples_ff;
         end
         SEG_FLUSH: begin
            freq_in = '0;
            len_in  = flush_samples_ff;
         end
         default: begin
            freq_in = '0;
            len_in  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_ff    <= 1'b0;
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (cmd.set_tx) begin
            tx_ff <= 1'b1;
         end else if (cmd.clr_tx) begin
            tx_ff <= 1'b0;
         end
         if (cmd.emit) begin
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff   <= req_op;
         word_ff <= req_data_word;
      end else if (cmd.shift) begin
         word_ff <= {1'b0, word_ff[WORD_W-1:1]};
      end
      if (cmd.emit) begin
         freq_ff <= freq_in;
         len_ff  <= len_in;
         last_ff <= cmd.seg_last;
      end
   end

   assign status.op           = op_ff;
   assign status.transmitting = tx_ff;
   assign status.cnt_zero     = (cnt_ff == '0);
   assign status.out_free     = !valid_ff || rsp_ready;

   assign rsp_valid    = valid_ff;
   assign rsp_seg_freq = freq_ff;
   assign rsp_duration = len_ff;
   assign rsp_last     = last_ff;

endmodule

[rtl/fsk_async_frame_tone_sequencer_top.sv]
// Binary-FSK async frame tone sequencer. A send item yields optional leader
// mark bits (first word of a transmission only), a space start bit, up to
// eight data bits LSB first and a mark stop bit; an end item yields trailer
// mark bits and a silent flush segment, or nothing while idle. The segment
// sequencer emits one segment per cycle while the result side takes them,
// but the dispatch state and the zero check that ends each run of leader,
// data or trailer bits emit nothing. One item is in work at a time;
// the next is taken once the last segment sits in the output register.
// Register writes are taken any cycle and should be made only while idle.
// Depends on fsk_pkg, fsk_req_if, fsk_rsp_if, fsk_ctrl and fsk_dp.

module fsk_async_frame_tone_sequencer_top
   import fsk_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   fsk_req_if.sink          req_if,
   fsk_rsp_if.source        rsp_if,
   input  logic             csr_we,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   fsk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   fsk_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_op        (req_if.op),
      .req_data_word (req_if.data_word),
      .cmd           (cmd),
      .status        (status),
      .rsp_valid     (rsp_if.valid),
      .rsp_ready     (rsp_if.ready),
      .rsp_seg_freq  (rsp_if.seg_freq),
      .rsp_duration  (rsp_if.duration),
      .rsp_last      (rsp_if.last)
   );

endmodule

[rtl/fsk_checker.sv]
// port-level checks of the fsk tone sequencer, bound to the top level
// depends on fsk_pkg

module fsk_checker
   import fsk_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [FREQ_W-1:0] rsp_seg_freq,
   input logic [LEN_W-1:0]  rsp_duration,
   input logic              rsp_last
);

   // stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_seg_freq)
         && $stable(rsp_duration) && $stable(rsp_last))
      else $error("rsp beat changed while stalled");

   // one item in work at a time
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req taken while previous item in work");

   // no new result beat right after an accept; a stalled older beat may remain
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !(rsp_valid && !rsp_ready) |=> !rsp_valid)
      else $error("rsp beat appeared without dispatch");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("outputs active right after reset");

endmodule

bind fsk_async_frame_tone_sequencer_top fsk_checker u_fsk_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_if.valid),
   .req_ready     (req_if.ready),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .rsp_seg_freq  (rsp_if.seg_freq),
   .rsp_duration  (rsp_if.duration),
   .rsp_last      (rsp_if.last)
);
